// ----- rtl/core/per_flow_round_robin_path_selector_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the per-flow round-robin path selector
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef PER_FLOW_ROUND_ROBIN_PATH_SELECTOR_ASSERT_SVH
`define PER_FLOW_ROUND_ROBIN_PATH_SELECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFRR_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pfrr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFRR_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pfrr assertion failed");

// Next-cycle implication that is also checked through reset.
`define PFRR_ASSERT_NXT_RST(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pfrr assertion failed");

`endif

// ----- rtl/core/pfrr_pkg.sv -----
// ----------------------------------------------------------------------------
// pfrr_pkg
// Types, field widths and constants shared by the path selector files.
// ----------------------------------------------------------------------------
`default_nettype none

package pfrr_pkg;

  localparam int KEY_W      = 32;
  localparam int ADDR_W     = 32;
  localparam int REPS_W     = 7;
  localparam int SLOT_W     = 6;
  localparam int LFSR_W     = 32;
  localparam int LFSR_BIT_W = 5;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h0000_0001;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_SELECT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_WAIT_REM,
    ST_RESP
  } state_t;

  // One step of the Galois LFSR, x^32 + x^22 + x^2 + x + 1.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pfrr_if.sv -----
// ----------------------------------------------------------------------------
// pfrr_in_if / pfrr_out_if
// Valid/ready channels for requests and results of the path selector.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfrr_in_if import pfrr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [KEY_W-1:0]  flow_key;
  logic [ADDR_W-1:0] core_address;
  logic [REPS_W-1:0] repeat_count;

  modport source (output valid, output req_type, output flow_key,
                  output core_address, output repeat_count, input ready);
  modport sink   (input valid, input req_type, input flow_key,
                  input core_address, input repeat_count, output ready);
endinterface

interface pfrr_out_if import pfrr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] chosen_address;
  logic [SLOT_W-1:0] chosen_slot;
  logic              address_valid;
  logic              overflow_flag;

  modport source (output valid, output chosen_address, output chosen_slot,
                  output address_valid, output overflow_flag, input ready);
  modport sink   (input valid, input chosen_address, input chosen_slot,
                  input address_valid, input overflow_flag, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pfrr_rem_unit.sv -----
// ----------------------------------------------------------------------------
// pfrr_rem_unit
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfrr_rem_unit import pfrr_pkg::*; #(
  parameter int DIV_W = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [LFSR_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [DIV_W-1:0]  remainder
);

  logic [LFSR_W-1:0]     num_r;
  logic [DIV_W-1:0]      rem_r;
  logic [DIV_W-1:0]      den_r;
  logic [LFSR_BIT_W-1:0] bit_r;
  logic                  busy_r;
  logic                  done_r;
  logic [DIV_W:0]        trial;
  logic [DIV_W:0]        diff;
  logic [DIV_W-1:0]      rem_nxt;

  // The partial remainder stays below the divisor, so the trial value is
  // below twice the divisor and one subtract settles each bit.
  always_comb begin
    trial   = {rem_r, num_r[LFSR_W-1]};
    diff    = trial - {1'b0, den_r};
    rem_nxt = diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && (bit_r == '0)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      bit_r <= LFSR_BIT_W'(LFSR_W - 1);
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= rem_nxt;
      bit_r <= bit_r - LFSR_BIT_W'(1);
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ----- rtl/core/per_flow_round_robin_path_selector.sv -----
// ----------------------------------------------------------------------------
// per_flow_round_robin_path_selector
// Weighted path list and per-flow round-robin choice of a core switch.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Transfer moves
//  -------  ---------  ---------------------------------------------------
//  in_ch    sink       req_type, flow_key, core_address, repeat_count
//  out_ch   source     chosen_address, chosen_slot, address_valid,
//                      overflow_flag
//
//  One request is in progress at a time. An add writes one list copy per
//  cycle, whether or not the list fills. A select on an empty list goes
//  straight to the result. A select of a stored flow scans the flow table
//  memory one entry per cycle until it finds the flow. A new flow waits for
//  the table scan and the remainder unit, which run together.
//  Reset is synchronous and needs no clearing pass: the flow table fills
//  from entry zero and a fill count marks the stored entries. No request is
//  taken while reset is asserted.
//  A result waits in the output register while out_ch stalls; the next
//  request is still taken, and its result waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module per_flow_round_robin_path_selector import pfrr_pkg::*; #(
  parameter int LIST_DEPTH   = 64,
  parameter int FLOW_ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  pfrr_in_if.sink    in_ch,
  pfrr_out_if.source out_ch
);

  // Width of the list fill count (holds LIST_DEPTH itself) and of an index.
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  // Width of the flow table fill count and of a table address.
  localparam int FW = $clog2(FLOW_ENTRIES + 1);
  localparam int FI = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  // The slot field carries the low bits of the list index.
  localparam int EW = (IW > SLOT_W) ? IW : SLOT_W;

  typedef struct packed {
    logic [KEY_W-1:0] tag;
    logic [IW-1:0]    next_slot;
  } flow_entry_t;

  // Next list index after i, wrapped to the list length n. The index is
  // always below n, so the sum never exceeds LIST_DEPTH.
  function automatic logic [IW-1:0] wrap_slot(input logic [IW-1:0] i,
                                               input logic [CW-1:0] n);
    logic [CW-1:0] s;
    s = CW'(i) + CW'(1);
    return (s == n) ? '0 : s[IW-1:0];
  endfunction

  // Control and request registers.
  state_t            state_r, state_nxt;
  logic [KEY_W-1:0]  key_r;
  logic [ADDR_W-1:0] addr_r;
  logic [REPS_W-1:0] reps_r, reps_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [FW-1:0]     scan_r, scan_nxt;
  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic              res_ovf_r, res_ovf_nxt;

  // Output register.
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_av_r;
  logic              out_ovf_r;
  logic              out_load;

  // Memories and their ports.
  logic [ADDR_W-1:0] path_mem [LIST_DEPTH];
  flow_entry_t       flow_mem [FLOW_ENTRIES];
  logic              path_we;
  logic [IW-1:0]     path_raddr;
  logic [ADDR_W-1:0] path_q;
  logic              flow_we;
  logic [FI-1:0]     flow_waddr;
  logic [FI-1:0]     flow_raddr;
  flow_entry_t       flow_wdata;
  flow_entry_t       flow_q;

  // Remainder unit for the random start of a new flow.
  logic              rem_start;
  logic              rem_done;
  logic [CW-1:0]     rem_value;

  logic              in_fire;
  logic [IW-1:0]     cand_idx;
  logic [EW-1:0]     idx_ext;

  assign in_fire = in_ch.valid && in_ch.ready;

  // The remainder is started for every select that finds a non-empty list,
  // in parallel with the table scan; only a miss waits for it.
  pfrr_rem_unit #(
    .DIV_W (CW)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (lfsr_r),
    .divisor   (count_r),
    .done      (rem_done),
    .remainder (rem_value)
  );

  // The index that is about to be used: the stored one on a hit, the
  // random start on a miss. The remainder is below the list length.
  assign cand_idx = (state_r == ST_SCAN) ? flow_q.next_slot : rem_value[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      fill_r  <= '0;
      lfsr_r  <= LFSR_SEED;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      fill_r  <= fill_nxt;
      lfsr_r  <= lfsr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r  <= in_ch.flow_key;
      addr_r <= in_ch.core_address;
    end
    reps_r      <= reps_nxt;
    scan_r      <= scan_nxt;
    idx_r       <= idx_nxt;
    res_valid_r <= res_valid_nxt;
    res_ovf_r   <= res_ovf_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    reps_nxt      = reps_r;
    count_nxt     = count_r;
    fill_nxt      = fill_r;
    scan_nxt      = scan_r;
    lfsr_nxt      = lfsr_r;
    idx_nxt       = idx_r;
    res_valid_nxt = res_valid_r;
    res_ovf_nxt   = res_ovf_r;
    in_ch.ready   = 1'b0;
    path_we       = 1'b0;
    path_raddr    = idx_r;
    flow_we       = 1'b0;
    flow_waddr    = fill_r[FI-1:0];
    flow_wdata    = '{tag: key_r, next_slot: wrap_slot(cand_idx, count_r)};
    flow_raddr    = '0;
    rem_start     = 1'b0;
    out_load      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        // Table entry zero is read here so the scan starts with its data.
        // Nothing is taken while reset is held.
        in_ch.ready = rst_n;
        if (in_ch.valid) begin
          res_valid_nxt = 1'b0;
          res_ovf_nxt   = 1'b0;
          idx_nxt       = '0;
          scan_nxt      = '0;
          case (in_ch.req_type)
            REQ_ADD: begin
              reps_nxt  = in_ch.repeat_count;
              state_nxt = ST_ADD;
            end
            REQ_SELECT: begin
              if (count_r == '0) begin
                state_nxt = ST_RESP;
              end else begin
                rem_start = 1'b1;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_ADD: begin
        // One copy per cycle; copies left over once the list is full
        // are dropped and flagged.
        if (reps_r == '0) begin
          state_nxt = ST_RESP;
        end else if (count_r == CW'(LIST_DEPTH)) begin
          res_ovf_nxt = 1'b1;
          state_nxt   = ST_RESP;
        end else begin
          path_we   = 1'b1;
          count_nxt = count_r + CW'(1);
          reps_nxt  = reps_r - REPS_W'(1);
        end
      end

      ST_SCAN: begin
        // flow_q holds entry scan_r. Stored keys are unique, so the first
        // match is the only one.
        if (scan_r == fill_r) begin
          state_nxt = ST_WAIT_REM;
        end else if (flow_q.tag == key_r) begin
          idx_nxt       = cand_idx;
          path_raddr    = cand_idx;
          flow_we       = 1'b1;
          flow_waddr    = scan_r[FI-1:0];
          res_valid_nxt = 1'b1;
          state_nxt     = ST_RESP;
        end else begin
          scan_nxt   = scan_r + FW'(1);
          flow_raddr = scan_nxt[FI-1:0];
        end
      end

      ST_WAIT_REM: begin
        // New flow: start at the LFSR value modulo the list length and
        // store it in the first free entry when there is one.
        if (rem_done) begin
          idx_nxt       = cand_idx;
          path_raddr    = cand_idx;
          lfsr_nxt      = lfsr_step(lfsr_r);
          res_valid_nxt = 1'b1;
          if (fill_r != FW'(FLOW_ENTRIES)) begin
            flow_we  = 1'b1;
            fill_nxt = fill_r + FW'(1);
          end else begin
            res_ovf_nxt = 1'b1;
          end
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        // path_q holds the entry at idx_r for a select.
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[count_r[IW-1:0]] <= addr_r;
    end
    path_q <= path_mem[path_raddr];
  end

  always_ff @(posedge clk) begin
    if (flow_we) begin
      flow_mem[flow_waddr] <= flow_wdata;
    end
    flow_q <= flow_mem[flow_raddr];
  end

  assign idx_ext = EW'(idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_addr_r <= res_valid_r ? path_q : '0;
      out_slot_r <= res_valid_r ? idx_ext[SLOT_W-1:0] : '0;
      out_av_r   <= res_valid_r;
      out_ovf_r  <= res_ovf_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.chosen_address = out_addr_r;
  assign out_ch.chosen_slot    = out_slot_r;
  assign out_ch.address_valid  = out_av_r;
  assign out_ch.overflow_flag  = out_ovf_r;

endmodule

`default_nettype wire

// ----- rtl/core/pfrr_checker.sv -----
// ----------------------------------------------------------------------------
// pfrr_checker
// Port-level checks of the path selector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_flow_round_robin_path_selector_assert.svh"

module pfrr_checker import pfrr_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ADDR_W-1:0] chosen_address,
  input wire logic [SLOT_W-1:0] chosen_slot,
  input wire logic              address_valid
);

  // A stalled result stays offered.
  `PFRR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // Only one request is in progress: no transfer directly after another.
  `PFRR_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  // A result without a chosen path carries a zero address and slot.
  `PFRR_ASSERT_IMP(a_no_path_zero, clk, rst_n, out_valid && !address_valid,
                   (chosen_address == '0) && (chosen_slot == '0))

  // Reset empties the output register.
  `PFRR_ASSERT_NXT_RST(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind per_flow_round_robin_path_selector pfrr_checker u_pfrr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .chosen_address (out_ch.chosen_address),
  .chosen_slot    (out_ch.chosen_slot),
  .address_valid  (out_ch.address_valid)
);

`default_nettype wire
